// ===== src/assert_macros.svh =====
// Assertion helpers. Each macro expects clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/ibb_pkg.sv =====
// ----------------------------------------------------------------------------
// ibb_pkg
// Shared constants, codes and control types of the pixel binning block.
// ----------------------------------------------------------------------------
package ibb_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_BIN    = 16;
  localparam int PIXEL_BITS = 16;

  localparam int COL_AW = $clog2(MAX_WIDTH);   // column sum address / x position
  localparam int ROW_W  = $clog2(MAX_HEIGHT);  // y position
  localparam int OFS_W  = $clog2(MAX_BIN);     // offset inside a block
  localparam int DIM_W  = 13;
  localparam int BIN_W  = 5;
  localparam int PIX_W  = 16;
  localparam int RUN_W  = 20;
  localparam int CSUM_W = 24;
  localparam int MEAN_W = 24;
  localparam int N_W    = 2 * BIN_W;           // bin_x * bin_y
  localparam int DVD_W  = 32;                  // sum * 256 + n / 2
  localparam int CNT_W  = $clog2(DVD_W);
  localparam int FRAC_W = 8;

  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = DIM_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_BIN_X        = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_BIN_Y        = CFG_IDX_W'(3);

  localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = DIM_W'(1024);
  localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = DIM_W'(1024);
  localparam logic [BIN_W-1:0] RST_BIN_X        = BIN_W'(2);
  localparam logic [BIN_W-1:0] RST_BIN_Y        = BIN_W'(2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MEAN,
    ST_DIV,
    ST_OUT,
    ST_CHKW_GO,
    ST_CHKW_WAIT,
    ST_CHKH_GO,
    ST_CHKH_WAIT
  } fsm_state_t;

  typedef struct packed {
    logic take;        // input word accepted
    logic cfg_wr;      // config word accepted
    logic col_wr;      // update column sum
    logic mean_go;     // start mean division
    logic chk_w_go;    // start width % bin_x
    logic chk_h_go;    // start height % bin_y
    logic chk_w_save;
    logic chk_h_save;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic geom_ok;
    logic blk_end;     // current pixel closes a block row segment
    logic emit;        // latched: block complete
    logic cfg_hit;     // config index names a register
    logic div_done;
    logic out_valid;
  } dp_stat_t;

endpackage

// ===== src/image_block_binning_top.sv =====
// ----------------------------------------------------------------------------
// image_block_binning_top
// Box-average pixel binning: row-major pixels in, one rounded mean with
// 8 fraction bits out for each bin_x by bin_y block.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid/in_ready    | in_pixel[15:0]
//  out     | output    | out_valid/out_ready  | out_mean_value[23:0], out_frame_end
//  cfg     | input     | cfg_valid/cfg_ready  | cfg_index[3:0], cfg_wdata[12:0]
//
// A pixel inside a block row segment is taken in IDLE; one that closes a segment
// also passes READ (column sum RAM read then write); one that completes a block
// then passes MEAN, DIV and OUT, waiting on the 32-step shared divider. A config
// write to a register starts a geometry check (two divider passes), with in and
// cfg ready low. Reset is synchronous; the column sum RAM is not cleared. A stalled
// output holds pixel intake only once the next result waits in OUT to load.
// ----------------------------------------------------------------------------
module image_block_binning_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ibb_pkg::PIX_W-1:0]      in_pixel,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ibb_pkg::MEAN_W-1:0]     out_mean_value,
  output logic                           out_frame_end,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ibb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ibb_pkg::CFG_DAT_W-1:0]  cfg_wdata
);
  import ibb_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  ibb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ibb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_pixel       (in_pixel),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_mean_value (out_mean_value),
    .out_frame_end  (out_frame_end)
  );

endmodule

// ===== src/ibb_ram.sv =====
// ----------------------------------------------------------------------------
// ibb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ibb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ibb_div.sv =====
// ----------------------------------------------------------------------------
// ibb_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ibb_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [ibb_pkg::DVD_W-1:0]  dividend,
  input  logic [ibb_pkg::N_W-1:0]    divisor,
  output logic                       done,
  output logic [ibb_pkg::DVD_W-1:0]  quo,
  output logic [ibb_pkg::N_W-1:0]    rem
);
  import ibb_pkg::*;

  logic             busy_r, done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [N_W-1:0]   rem_r, dvs_r;
  logic [N_W:0]     rem_sh, diff;
  logic             ge;

  // dividend bits shift out of quo_r as quotient bits shift in
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DVD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DVD_W-2:0], ge};
      rem_r <= ge ? diff[N_W-1:0] : rem_sh[N_W-1:0];
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

  `ASSERT_IMPLIES(a_no_restart, start, !busy_r, "divider started while busy")
  `ASSERT_IMPLIES(a_done_on_fall, $fell(busy_r), done_r, "divider finished without done")

endmodule

// ===== src/ibb_dp.sv =====
// ----------------------------------------------------------------------------
// ibb_dp
// Binning datapath: config registers, position counters, column sum RAM,
// divider and output register.
// ----------------------------------------------------------------------------
module ibb_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ibb_pkg::ctrl_cmd_t             cmd,
  output ibb_pkg::dp_stat_t              stat,
  input  logic [ibb_pkg::PIX_W-1:0]      in_pixel,
  input  logic [ibb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ibb_pkg::CFG_DAT_W-1:0]  cfg_wdata,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [ibb_pkg::MEAN_W-1:0]     out_mean_value,
  output logic                           out_frame_end
);
  import ibb_pkg::*;

  // configuration
  logic [DIM_W-1:0] width_r, height_r;
  logic [BIN_W-1:0] binx_r, biny_r;
  logic             geom_ok_r, wrem0_r;
  logic             range_ok, cfg_hit;
  logic [N_W-1:0]   n_r;

  // frame position
  logic [COL_AW-1:0] xpos_r, col_r;
  logic [ROW_W-1:0]  ypos_r;
  logic [OFS_W-1:0]  xib_r, yib_r;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [BIN_W-1:0]  binx_m1, biny_m1;
  logic [DIM_W-1:0]  width_m1, height_m1;
  logic              blk_end, blk_last_row, row_end, frame_last, advance;

  // per-block work
  logic              emit_r, last_r, ystart_r;
  logic [COL_AW-1:0] col_wa_r;
  logic [CSUM_W-1:0] ram_rdata, csum, sum_r;

  // divider
  logic              div_start, div_done;
  logic [DVD_W-1:0]  div_dvd, div_quo;
  logic [N_W-1:0]    div_dvs, div_rem;

  // output register
  logic              out_valid_r, frame_end_r;
  logic [MEAN_W-1:0] mean_r;

  assign range_ok = (width_r  >= DIM_W'(1)) && (width_r  <= DIM_W'(MAX_WIDTH))  &&
                    (height_r >= DIM_W'(1)) && (height_r <= DIM_W'(MAX_HEIGHT)) &&
                    (binx_r   >= BIN_W'(1)) && (binx_r   <= BIN_W'(MAX_BIN))    &&
                    (biny_r   >= BIN_W'(1)) && (biny_r   <= BIN_W'(MAX_BIN));

  always_comb begin
    case (cfg_index)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_BIN_X, REG_BIN_Y: cfg_hit = 1'b1;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign binx_m1    = binx_r - BIN_W'(1);
  assign biny_m1    = biny_r - BIN_W'(1);
  assign width_m1   = width_r - DIM_W'(1);
  assign height_m1  = height_r - DIM_W'(1);
  assign blk_end    = {1'b0, xib_r} == binx_m1;
  assign blk_last_row = {1'b0, yib_r} == biny_m1;
  assign row_end    = {1'b0, xpos_r} == width_m1;
  assign frame_last = row_end && ({1'b0, ypos_r} == height_m1);
  assign advance    = cmd.take && geom_ok_r;
  assign run_nxt    = (xib_r == '0) ? RUN_W'(in_pixel[PIXEL_BITS-1:0])
                                    : run_r + RUN_W'(in_pixel[PIXEL_BITS-1:0]);

  // config and frame position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= RST_IMAGE_WIDTH;
      height_r  <= RST_IMAGE_HEIGHT;
      binx_r    <= RST_BIN_X;
      biny_r    <= RST_BIN_Y;
      geom_ok_r <= 1'b1;
      xpos_r    <= '0;
      ypos_r    <= '0;
      xib_r     <= '0;
      yib_r     <= '0;
      col_r     <= '0;
      run_r     <= '0;
    end else if (cmd.cfg_wr) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[DIM_W-1:0];
        REG_BIN_X:        binx_r   <= cfg_wdata[BIN_W-1:0];
        REG_BIN_Y:        biny_r   <= cfg_wdata[BIN_W-1:0];
        default: ;
      endcase
      if (cfg_hit) begin
        // frame restarts; geometry is rechecked before the next pixel
        geom_ok_r <= 1'b0;
        xpos_r    <= '0;
        ypos_r    <= '0;
        xib_r     <= '0;
        yib_r     <= '0;
        col_r     <= '0;
        run_r     <= '0;
      end
    end else if (cmd.chk_h_save) begin
      geom_ok_r <= range_ok && wrem0_r && (div_rem == '0);
    end else if (advance) begin
      run_r <= run_nxt;
      if (row_end) begin
        xpos_r <= '0;
        xib_r  <= '0;
        col_r  <= '0;
        if ({1'b0, ypos_r} == height_m1) begin
          ypos_r <= '0;
          yib_r  <= '0;
        end else begin
          ypos_r <= ypos_r + ROW_W'(1);
          yib_r  <= blk_last_row ? '0 : yib_r + OFS_W'(1);
        end
      end else begin
        xpos_r <= xpos_r + COL_AW'(1);
        if (blk_end) begin
          xib_r <= '0;
          col_r <= col_r + COL_AW'(1);
        end else begin
          xib_r <= xib_r + OFS_W'(1);
        end
      end
    end
  end

  // block bookkeeping, no reset needed
  always_ff @(posedge clk) begin
    n_r <= N_W'(binx_r) * N_W'(biny_r);
    if (cmd.chk_w_save) begin
      wrem0_r <= div_rem == '0;
    end
    if (advance) begin
      emit_r   <= blk_end && blk_last_row;
      last_r   <= frame_last;
      ystart_r <= yib_r == '0;
      col_wa_r <= col_r;
    end
    if (cmd.col_wr) begin
      sum_r <= csum;
    end
  end

  // first row of a block band overwrites, so unwritten entries are never used
  assign csum = ystart_r ? CSUM_W'(run_r) : ram_rdata + CSUM_W'(run_r);

  ibb_ram #(
    .WIDTH (CSUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_ram (
    .clk   (clk),
    .we    (cmd.col_wr),
    .waddr (col_wa_r),
    .wdata (csum),
    .re    (advance && blk_end),
    .raddr (col_r),
    .rdata (ram_rdata)
  );

  assign div_start = cmd.mean_go || cmd.chk_w_go || cmd.chk_h_go;

  always_comb begin
    if (cmd.mean_go) begin
      div_dvd = {sum_r, FRAC_W'(0)} + DVD_W'(n_r >> 1);
      div_dvs = n_r;
    end else if (cmd.chk_w_go) begin
      div_dvd = DVD_W'(width_r);
      div_dvs = N_W'(binx_r);
    end else begin
      div_dvd = DVD_W'(height_r);
      div_dvs = N_W'(biny_r);
    end
  end

  ibb_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mean_r      <= div_quo[MEAN_W-1:0];
      frame_end_r <= last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean_value = mean_r;
  assign out_frame_end  = frame_end_r;

  assign stat.geom_ok   = geom_ok_r;
  assign stat.blk_end   = blk_end;
  assign stat.emit      = emit_r;
  assign stat.cfg_hit   = cfg_hit;
  assign stat.div_done  = div_done;
  assign stat.out_valid = out_valid_r;

endmodule

// ===== src/ibb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ibb_ctrl
// Binning controller: sequences pixel, column update, division and
// geometry check after config writes.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ibb_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               out_ready,
  input  ibb_pkg::dp_stat_t  stat,
  output ibb_pkg::ctrl_cmd_t cmd
);
  import ibb_pkg::*;

  fsm_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // config word wins over a pixel offered in the same cycle
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
          if (stat.cfg_hit) begin
            state_nxt = ST_CHKW_GO;
          end
        end else if (in_valid) begin
          cmd.take = 1'b1;
          if (stat.geom_ok && stat.blk_end) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.col_wr = 1'b1;
        state_nxt  = stat.emit ? ST_MEAN : ST_IDLE;
      end
      ST_MEAN: begin
        cmd.mean_go = 1'b1;
        state_nxt   = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!stat.out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_CHKW_GO: begin
        cmd.chk_w_go = 1'b1;
        state_nxt    = ST_CHKW_WAIT;
      end
      ST_CHKW_WAIT: begin
        if (stat.div_done) begin
          cmd.chk_w_save = 1'b1;
          state_nxt      = ST_CHKH_GO;
        end
      end
      ST_CHKH_GO: begin
        cmd.chk_h_go = 1'b1;
        state_nxt    = ST_CHKH_WAIT;
      end
      ST_CHKH_WAIT: begin
        if (stat.div_done) begin
          cmd.chk_h_save = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  `ASSERT_IMPLIES(a_read_after_take, state_r == ST_READ, $past(in_valid && in_ready), "column update without a pixel")
  `ASSERT_IMPLIES(a_out_free, cmd.out_load, !stat.out_valid || out_ready, "output register overwritten")

endmodule
